>>> sv/ngc_pkg.sv
// ----------------------------------------------------------------------------
// ngc_pkg
// shared codes and types of the n-ary gray counter unit
// ----------------------------------------------------------------------------
package ngc_pkg;

  // width used for compares that mix the 9-bit base, 8-bit digits and the cap
  localparam int WIDE_W = 17;

  typedef enum logic [0:0] {
    OP_LOAD = 1'b0,
    OP_INC  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_DIGIT = 2'd1,
    STATUS_BAD_POS   = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    CFG_BASE  = 1'b0,
    CFG_COUNT = 1'b1
  } cfg_reg_t;

  // where a digit lies relative to the digit that takes the carry
  typedef enum logic [1:0] {
    REL_BELOW = 2'd0,
    REL_AT    = 2'd1,
    REL_ABOVE = 2'd2
  } pos_rel_t;

  typedef struct packed {
    logic     dec_pass;
    logic     par;
    pos_rel_t rel;
  } alu_ctl_t;

endpackage

>>> sv/ngc_digit_ram.sv
// ----------------------------------------------------------------------------
// ngc_digit_ram
// digit store: one write port, one registered read port, per-entry valid bits
// ----------------------------------------------------------------------------
module ngc_digit_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] ent_vld;
  logic [WIDTH-1:0] rd_data;
  logic             rd_vld;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_vld <= '0;
      rd_vld  <= 1'b0;
    end else begin
      if (we) begin
        ent_vld[waddr] <= 1'b1;
      end
      rd_vld <= ent_vld[raddr];
    end
  end

  // never written entries read as zero
  assign rdata = rd_vld ? rd_data : '0;

endmodule

>>> sv/ngc_digit_alu.sv
// ----------------------------------------------------------------------------
// ngc_digit_alu
// per-digit gray decode, and carry plus gray encode
// ----------------------------------------------------------------------------
module ngc_digit_alu #(
  parameter int DIGIT_WIDTH = 8
) (
  input  ngc_pkg::alu_ctl_t        ctl,
  input  logic [DIGIT_WIDTH:0]     b,
  input  logic [DIGIT_WIDTH-1:0]   d_in,
  output logic [DIGIT_WIDTH-1:0]   d_out,
  output logic                     d_odd,
  output logic                     d_max
);

  localparam int BW = DIGIT_WIDTH + 1;

  logic [BW-1:0] dx;
  logic [BW-1:0] bm1;
  logic [BW-1:0] gc;
  logic [BW-1:0] v_dec;
  logic [BW-1:0] v_enc;
  logic [BW-1:0] g_enc;

  always_comb begin
    dx  = BW'(d_in);
    bm1 = b - BW'(1);
    // stored digit at or above the base counts as base-1
    gc    = (dx >= b) ? bm1 : dx;
    v_dec = ctl.par ? (bm1 - gc) : gc;
    unique case (ctl.rel)
      ngc_pkg::REL_BELOW: v_enc = dx;
      ngc_pkg::REL_AT:    v_enc = dx + BW'(1);
      default:            v_enc = '0;
    endcase
    g_enc = ctl.par ? (bm1 - v_enc) : v_enc;
    d_out = ctl.dec_pass ? v_dec[DIGIT_WIDTH-1:0] : g_enc[DIGIT_WIDTH-1:0];
    d_odd = ctl.dec_pass ? v_dec[0] : v_enc[0];
    d_max = (v_dec == bm1);
  end

endmodule

>>> sv/nary_gray_counter_unit.sv
// ----------------------------------------------------------------------------
// nary_gray_counter_unit
// reflected base-n gray word with single-digit load and whole-word increment
// ----------------------------------------------------------------------------
// load: answers in the next cycle after its transfer and never makes the unit busy.
// increment of n digits: one decode pass and one encode pass over the digit
//   store's single read port; results come out during the encode pass.
// base below two: encode pass only, with the stored digits passed through unchanged.
// throughput: one item per busy period, set by the store's one read per cycle.
// reset: base 2, digit count 1, store valid bits cleared so every digit reads 0.
// ----------------------------------------------------------------------------
module nary_gray_counter_unit #(
  parameter int MAX_DIGIT_COUNT = 64,
  parameter int DIGIT_WIDTH     = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic       operation,
  input  logic [5:0] digit_position,
  input  logic [7:0] digit_value,
  input  logic       cfg_write,
  input  logic [0:0] cfg_index,
  input  logic [8:0] cfg_data,
  output logic       strobe,
  output logic [7:0] out_digit,
  output logic [5:0] out_position,
  output logic       last,
  output logic       wrapped,
  output logic [1:0] status
);

  localparam int AW = (MAX_DIGIT_COUNT > 1) ? $clog2(MAX_DIGIT_COUNT) : 1;
  localparam int BW = DIGIT_WIDTH + 1;
  localparam int CW = ngc_pkg::WIDE_W;

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_DEC      = 5'b00010,
    S_DEC_WAIT = 5'b00100,
    S_ENC      = 5'b01000,
    S_ENC_WAIT = 5'b10000
  } state_t;

  state_t state;

  logic [8:0]             cfg_base;
  logic [6:0]             cfg_count;
  logic [CW-1:0]          b_wide;
  logic [CW-1:0]          cap_wide;
  logic [BW-1:0]          b;
  logic [6:0]             n;
  logic [6:0]             n_m1;
  logic                   b_lt2;

  logic [AW-1:0]          rd_idx;
  logic                   p_vld;
  logic                   p_dec;
  logic [AW-1:0]          p_idx;
  logic                   par;
  logic                   carry_ok;
  logic [AW-1:0]          carry_idx;
  logic                   thru;

  logic                   accept;
  logic                   load_bad_digit;
  logic                   load_bad_pos;
  logic                   load_wr;
  logic                   issue;
  logic                   issue_last;
  logic                   p_last;

  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [DIGIT_WIDTH-1:0] mem_wdata;
  logic [DIGIT_WIDTH-1:0] mem_rdata;

  ngc_pkg::alu_ctl_t      alu_ctl;
  logic [DIGIT_WIDTH-1:0] alu_out;
  logic                   alu_odd;
  logic                   alu_max;

  // effective base and count after saturation
  always_comb begin
    cap_wide = CW'(1) << DIGIT_WIDTH;
    b_wide   = (CW'(cfg_base) > cap_wide) ? cap_wide : CW'(cfg_base);
    b        = b_wide[BW-1:0];
    n        = (cfg_count > 7'(MAX_DIGIT_COUNT)) ? 7'(MAX_DIGIT_COUNT) : cfg_count;
    n_m1     = n - 7'd1;
    b_lt2    = (b < BW'(2));
  end

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    load_bad_digit = b_lt2 || (CW'(digit_value) >= b_wide);
    load_bad_pos   = (7'(digit_position) >= n);
    load_wr        = accept && (operation == ngc_pkg::OP_LOAD) &&
                     !load_bad_digit && !load_bad_pos;
    issue          = (state == S_DEC) || (state == S_ENC);
    issue_last     = (7'(rd_idx) == n_m1);
    p_last         = (7'(p_idx) == n_m1);
  end

  always_comb begin
    alu_ctl.dec_pass = p_dec;
    alu_ctl.par      = par;
    if (!carry_ok || (p_idx > carry_idx)) begin
      alu_ctl.rel = ngc_pkg::REL_ABOVE;
    end else if (p_idx == carry_idx) begin
      alu_ctl.rel = ngc_pkg::REL_AT;
    end else begin
      alu_ctl.rel = ngc_pkg::REL_BELOW;
    end
  end

  always_comb begin
    mem_we    = load_wr || (p_vld && (p_dec || !thru));
    mem_waddr = load_wr ? digit_position[AW-1:0] : p_idx;
    mem_wdata = load_wr ? DIGIT_WIDTH'(digit_value) : alu_out;
  end

  ngc_digit_ram #(
    .DEPTH (MAX_DIGIT_COUNT),
    .WIDTH (DIGIT_WIDTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .rst   (rst),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (rd_idx),
    .rdata (mem_rdata)
  );

  ngc_digit_alu #(
    .DIGIT_WIDTH (DIGIT_WIDTH)
  ) u_alu (
    .ctl   (alu_ctl),
    .b     (b),
    .d_in  (mem_rdata),
    .d_out (alu_out),
    .d_odd (alu_odd),
    .d_max (alu_max)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_base  <= 9'd2;
      cfg_count <= 7'd1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ngc_pkg::CFG_BASE:  cfg_base  <= cfg_data;
        ngc_pkg::CFG_COUNT: cfg_count <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // control: pass sequencer and read pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      rd_idx   <= '0;
      p_vld    <= 1'b0;
      p_dec    <= 1'b0;
      thru     <= 1'b0;
      carry_ok <= 1'b0;
      par      <= 1'b0;
    end else begin
      p_vld <= issue;
      p_dec <= (state == S_DEC);
      if (p_vld) begin
        // parity restarts for the encode pass after the last decoded digit
        if (state != S_DEC_WAIT) begin
          par <= par ^ alu_odd;
        end
        if (p_dec && !alu_max) begin
          carry_ok <= 1'b1;
        end
      end
      unique case (state)
        S_IDLE: begin
          rd_idx <= '0;
          if (accept && (operation == ngc_pkg::OP_INC) && (n != 7'd0)) begin
            par      <= 1'b0;
            carry_ok <= 1'b0;
            thru     <= b_lt2;
            state    <= b_lt2 ? S_ENC : S_DEC;
          end
        end
        S_DEC: begin
          if (issue_last) begin
            state <= S_DEC_WAIT;
          end else begin
            rd_idx <= rd_idx + AW'(1);
          end
        end
        S_DEC_WAIT: begin
          rd_idx <= '0;
          par    <= 1'b0;
          state  <= S_ENC;
        end
        S_ENC: begin
          if (issue_last) begin
            state <= S_ENC_WAIT;
          end else begin
            rd_idx <= rd_idx + AW'(1);
          end
        end
        S_ENC_WAIT: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    p_idx <= rd_idx;
    if (p_vld && p_dec && !alu_max) begin
      carry_idx <= p_idx;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= (accept && ((operation == ngc_pkg::OP_LOAD) || (n == 7'd0))) ||
                (p_vld && !p_dec);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (operation == ngc_pkg::OP_LOAD)) begin
      out_digit    <= digit_value;
      out_position <= digit_position;
      last         <= 1'b1;
      wrapped      <= 1'b0;
      if (load_bad_digit) begin
        status <= ngc_pkg::STATUS_BAD_DIGIT;
      end else if (load_bad_pos) begin
        status <= ngc_pkg::STATUS_BAD_POS;
      end else begin
        status <= ngc_pkg::STATUS_OK;
      end
    end else if (accept) begin
      // any increment start; strobe marks this result only for an empty word
      out_digit    <= 8'd0;
      out_position <= 6'd0;
      last         <= 1'b1;
      wrapped      <= 1'b0;
      status       <= ngc_pkg::STATUS_BAD_POS;
    end else if (p_vld && !p_dec) begin
      out_digit    <= thru ? 8'(mem_rdata) : 8'(alu_out);
      out_position <= 6'(p_idx);
      last         <= p_last;
      wrapped      <= !thru && !carry_ok;
      status       <= ngc_pkg::STATUS_OK;
    end
  end

  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !p_vld)
    else $error("read pipeline busy while idle");

  a_last_ends_item: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |-> !busy)
    else $error("final transfer while still busy");

  a_load_answers: assert property (@(posedge clk) disable iff (rst)
    (accept && (operation == ngc_pkg::OP_LOAD)) |=> (strobe && last))
    else $error("load gave no single result");

  a_enc_no_carry_write: assert property (@(posedge clk) disable iff (rst)
    (p_vld && !p_dec && thru) |-> !mem_we)
    else $error("store written while passing digits through");

endmodule
